// ===== src/gfp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package gfp_pkg;

  localparam int SIZE   = 4;
  localparam int FRAC   = 16;
  localparam int IDX_W  = 2;
  localparam int COL_W  = 3;
  localparam int ADDR_W = 1 + IDX_W + COL_W;
  localparam int DATA_W = 32;

  localparam logic BANK_MAT = 1'b0;
  localparam logic BANK_RET = 1'b1;

  typedef enum logic [1:0] {
    WS_IN,
    WS_ZERO,
    WS_RD,
    WS_SUB
  } wsel_t;

  typedef enum logic [4:0] {
    ST_IDLE,
    ST_INIT,
    ST_S_RD,
    ST_S_CMP,
    ST_S_END,
    ST_E_RDF,
    ST_E_DIVS,
    ST_E_DIVW,
    ST_E_RDP,
    ST_E_MUL,
    ST_E_RND,
    ST_E_WR,
    ST_R_RD,
    ST_R_WR,
    ST_R_CLR,
    ST_B_RD,
    ST_B_CHK,
    ST_B_DIVS,
    ST_B_DIVW,
    ST_B_RR,
    ST_B_RM,
    ST_B_RND,
    ST_B_RW,
    ST_B_RZ,
    ST_OUT
  } state_t;

  typedef struct packed {
    logic              mem_we;
    logic [ADDR_W-1:0] mem_addr;
    wsel_t             wsel;
    logic              piv_ld;
    logic              div_start;
    logic              f_ld;
    logic              sol_ld;
    logic [IDX_W-1:0]  sol_idx;
    logic              sol_clr;
    logic              sing_set;
    logic              sing_clr;
    logic [IDX_W-1:0]  out_idx;
  } cmd_t;

  typedef struct packed {
    logic rd_zero;
    logic mag_gt;
    logic best_zero;
    logic div_done;
  } stat_t;

  function automatic logic [DATA_W-1:0] mag32(input logic [DATA_W-1:0] v);
    return v[DATA_W-1] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [DATA_W-1:0] sat_mag(input logic [63:0] m, input logic neg);
    if (neg) begin
      return (m > 64'h0000_0000_8000_0000) ? 32'h8000_0000 : (~m[31:0] + 32'd1);
    end
    return (m > 64'h0000_0000_7fff_ffff) ? 32'h7fff_ffff : m[31:0];
  endfunction

  function automatic logic [ADDR_W-1:0] mk_addr(input logic bank,
                                                input logic [IDX_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    return {bank, row, col};
  endfunction

endpackage

`default_nettype wire

// ===== src/gfp_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface gfp_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         row_index;
  logic [2:0]         column_index;
  logic signed [31:0] element_value;
  logic               last_element;

  modport source (output valid, row_index, column_index, element_value, last_element,
                  input ready);
  modport sink (input valid, row_index, column_index, element_value, last_element,
                output ready);
endinterface

interface gfp_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         unknown_index;
  logic signed [31:0] unknown_value;
  logic               singular;
  logic               last_result;

  modport source (output valid, unknown_index, unknown_value, singular, last_result,
                  input ready);
  modport sink (input valid, unknown_index, unknown_value, singular, last_result,
                output ready);
endinterface

`default_nettype wire

// ===== src/gauss_full_pivot_solver.sv =====
// Full-pivot Gaussian elimination solver for a 4 x 5 augmented matrix in
// signed Q16.16.
// Input channel in_ch: one matrix element per word (row, column, value,
// last flag). Words are taken one per cycle while the block is idle; an
// element outside the matrix is dropped. The word with last_element set
// stores its element (if inside the matrix) and starts the solve;
// in_ch.ready stays low until the last result has been taken.
// Output channel out_ch: four words, unknowns 0 to 3 in order, each with
// the singular flag; last_result marks unknown 3.
// A solve is paced by the single port of the working memory (one element
// read or written per cycle) and the shared divider, which yields one
// quotient bit a cycle. Results then leave at one word per cycle while
// the receiver is ready.
// A receiver stall holds the current result word and the solver waits.
// Reset (rst_n low, synchronous) returns the block to idle with all rows
// active and cleared results; matrix contents stay undefined until loaded.
`timescale 1ns / 1ps
`default_nettype none

module gauss_full_pivot_solver (
  input  wire logic clk,
  input  wire logic rst_n,
  gfp_in_if.sink    in_ch,
  gfp_out_if.source out_ch
);

  gfp_pkg::cmd_t  cmd;
  gfp_pkg::stat_t stat;
  logic [31:0]    out_value;

  gfp_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_row    (in_ch.row_index),
    .in_col    (in_ch.column_index),
    .in_last   (in_ch.last_element),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .out_last  (out_ch.last_result),
    .cmd       (cmd),
    .stat      (stat)
  );

  gfp_datapath u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_value     (in_ch.element_value),
    .stat         (stat),
    .out_value    (out_value),
    .out_singular (out_ch.singular)
  );

  assign out_ch.unknown_value = out_value;
  assign out_ch.unknown_index = cmd.out_idx;

endmodule

`default_nettype wire

// ===== src/gfp_div.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfp_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [31:0] a,
  input  wire logic [31:0] b,
  output logic             done,
  output logic [31:0]      q
);

  localparam int NW    = 32 + gfp_pkg::FRAC + 1;
  localparam int CNT_W = $clog2(NW + 1);

  logic             busy_r;
  logic             done_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NW-1:0]    num_r;
  logic [31:0]      rem_r;
  logic [31:0]      d_r;
  logic             neg_r;
  logic             dz_r;
  logic [31:0]      q_r;

  logic [32:0] trial;
  logic [32:0] diff;
  logic        ge;

  assign trial = {rem_r, num_r[NW-1]};
  assign diff  = trial - {1'b0, d_r};
  assign ge    = trial >= {1'b0, d_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(NW);
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - 1'b1;
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= (NW'(gfp_pkg::mag32(a)) << gfp_pkg::FRAC) + NW'(gfp_pkg::mag32(b) >> 1);
      d_r   <= gfp_pkg::mag32(b);
      neg_r <= a[31] ^ b[31];
      dz_r  <= (b == '0);
      rem_r <= '0;
    end else if (busy_r) begin
      if (cnt_r != '0) begin
        num_r <= {num_r[NW-2:0], ge};
        rem_r <= ge ? diff[31:0] : trial[31:0];
      end else begin
        q_r <= dz_r ? '0 : gfp_pkg::sat_mag(64'(num_r), neg_r);
      end
    end
  end

  assign done = done_r;
  assign q    = q_r;

endmodule

`default_nettype wire

// ===== src/gfp_datapath.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfp_datapath (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire gfp_pkg::cmd_t cmd,
  input  wire logic [31:0]   in_value,
  output gfp_pkg::stat_t     stat,
  output logic [31:0]        out_value,
  output logic               out_singular
);

  localparam int DEPTH = 2 ** gfp_pkg::ADDR_W;
  localparam logic [63:0] HALF = 64'd1 << (gfp_pkg::FRAC - 1);

  logic [31:0] mem_r [DEPTH];
  logic [31:0] rd_r;
  logic [31:0] piv_r;
  logic [31:0] best_r;
  logic [31:0] f_r;
  logic [63:0] mul_r;
  logic        mul_neg_r;
  logic [31:0] prod_r;
  logic [31:0] old_r;
  logic [31:0] sol_r [gfp_pkg::SIZE];
  logic        sing_r;

  logic [31:0] wdata;
  logic [32:0] diff;
  logic [31:0] sub_sat;
  logic [63:0] rounded;
  logic        div_done;
  logic [31:0] div_q;

  assign diff    = {old_r[31], old_r} - {prod_r[31], prod_r};
  assign sub_sat = (diff[32] != diff[31]) ? (diff[32] ? 32'h8000_0000 : 32'h7fff_ffff)
                                          : diff[31:0];
  assign rounded = (mul_r + HALF) >> gfp_pkg::FRAC;

  always_comb begin
    case (cmd.wsel)
      gfp_pkg::WS_IN:   wdata = in_value;
      gfp_pkg::WS_ZERO: wdata = '0;
      gfp_pkg::WS_RD:   wdata = rd_r;
      gfp_pkg::WS_SUB:  wdata = sub_sat;
      default:          wdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.mem_we) begin
      mem_r[cmd.mem_addr] <= wdata;
    end
    rd_r <= mem_r[cmd.mem_addr];
  end

  always_ff @(posedge clk) begin
    if (cmd.piv_ld) begin
      piv_r  <= rd_r;
      best_r <= gfp_pkg::mag32(rd_r);
    end
    if (cmd.f_ld) begin
      f_r <= div_q;
    end
    mul_r     <= 64'(gfp_pkg::mag32(rd_r)) * 64'(gfp_pkg::mag32(f_r));
    mul_neg_r <= rd_r[31] ^ f_r[31];
    prod_r    <= gfp_pkg::sat_mag(rounded, mul_neg_r);
    old_r     <= rd_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sing_r <= 1'b0;
      for (int i = 0; i < gfp_pkg::SIZE; i++) begin
        sol_r[i] <= '0;
      end
    end else begin
      if (cmd.sing_clr) begin
        sing_r <= 1'b0;
      end else if (cmd.sing_set) begin
        sing_r <= 1'b1;
      end
      if (cmd.sol_clr) begin
        for (int i = 0; i < gfp_pkg::SIZE; i++) begin
          sol_r[i] <= '0;
        end
      end else if (cmd.sol_ld) begin
        sol_r[cmd.sol_idx] <= div_q;
      end
    end
  end

  gfp_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .a     (rd_r),
    .b     (piv_r),
    .done  (div_done),
    .q     (div_q)
  );

  assign stat.rd_zero   = (rd_r == '0);
  assign stat.mag_gt    = (gfp_pkg::mag32(rd_r) > best_r);
  assign stat.best_zero = (best_r == '0);
  assign stat.div_done  = div_done;

  assign out_value    = sol_r[cmd.out_idx];
  assign out_singular = sing_r;

endmodule

`default_nettype wire

// ===== src/gfp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfp_ctrl (
  input  wire logic                      clk,
  input  wire logic                      rst_n,
  input  wire logic                      in_valid,
  input  wire logic [gfp_pkg::IDX_W-1:0] in_row,
  input  wire logic [gfp_pkg::COL_W-1:0] in_col,
  input  wire logic                      in_last,
  output logic                           in_ready,
  output logic                           out_valid,
  input  wire logic                      out_ready,
  output logic                           out_last,
  output gfp_pkg::cmd_t                  cmd,
  input  wire gfp_pkg::stat_t            stat
);

  localparam int IW = gfp_pkg::IDX_W;
  localparam int CW = gfp_pkg::COL_W;
  localparam int N  = gfp_pkg::SIZE;
  localparam logic [IW-1:0] LAST_ROW  = IW'(N - 1);
  localparam logic [CW-1:0] LAST_COEF = CW'(N - 1);
  localparam logic [CW-1:0] RHS_COL   = CW'(N);

  gfp_pkg::state_t st_r, st_nxt;
  logic [IW-1:0] k_r, k_nxt;
  logic [IW-1:0] ci_r, ci_nxt;
  logic [CW-1:0] cj_r, cj_nxt;
  logic [IW-1:0] cr_r, cr_nxt;
  logic [IW-1:0] pr_r, pr_nxt;
  logic [IW-1:0] pc_r, pc_nxt;
  logic [IW-1:0] oi_r, oi_nxt;
  logic [N-1:0]  act_r, act_nxt;
  logic          found_r, found_nxt;

  logic in_acc, out_acc, take, cj_is_pc, row_skip;
  logic col_end, row_end, j_end, i_end, r_end, r_self;
  gfp_pkg::state_t bj_next, e_next;

  assign in_acc   = in_valid && in_ready;
  assign out_acc  = out_valid && out_ready;
  assign take     = act_r[ci_r] && (!found_r || stat.mag_gt);
  assign cj_is_pc = (cj_r == CW'(pc_r));
  assign row_skip = (ci_r == pr_r) || !act_r[ci_r];
  assign col_end  = (cj_r == RHS_COL);
  assign row_end  = (ci_r == LAST_ROW);
  assign j_end    = (cj_r == LAST_COEF);
  assign i_end    = (ci_r == '0);
  assign r_end    = (cr_r == LAST_ROW);
  assign r_self   = (cr_r == ci_r);
  assign bj_next  = (j_end && i_end) ? gfp_pkg::ST_OUT : gfp_pkg::ST_B_RD;
  assign e_next   = col_end ? (row_end ? gfp_pkg::ST_R_RD : gfp_pkg::ST_E_RDF)
                            : gfp_pkg::ST_E_RDP;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r    <= gfp_pkg::ST_IDLE;
      k_r     <= '0;
      ci_r    <= '0;
      cj_r    <= '0;
      cr_r    <= '0;
      pr_r    <= '0;
      pc_r    <= '0;
      oi_r    <= '0;
      act_r   <= '1;
      found_r <= 1'b0;
    end else begin
      st_r    <= st_nxt;
      k_r     <= k_nxt;
      ci_r    <= ci_nxt;
      cj_r    <= cj_nxt;
      cr_r    <= cr_nxt;
      pr_r    <= pr_nxt;
      pc_r    <= pc_nxt;
      oi_r    <= oi_nxt;
      act_r   <= act_nxt;
      found_r <= found_nxt;
    end
  end

  always_comb begin
    st_nxt = st_r;
    case (st_r)
      gfp_pkg::ST_IDLE:   if (in_acc && in_last) st_nxt = gfp_pkg::ST_INIT;
      gfp_pkg::ST_INIT:   st_nxt = gfp_pkg::ST_S_RD;
      gfp_pkg::ST_S_RD:   st_nxt = gfp_pkg::ST_S_CMP;
      gfp_pkg::ST_S_CMP:  st_nxt = (j_end && row_end) ? gfp_pkg::ST_S_END : gfp_pkg::ST_S_RD;
      gfp_pkg::ST_S_END:  st_nxt = stat.best_zero ? gfp_pkg::ST_R_RD : gfp_pkg::ST_E_RDF;
      gfp_pkg::ST_E_RDF: begin
        if (row_skip) st_nxt = row_end ? gfp_pkg::ST_R_RD : gfp_pkg::ST_E_RDF;
        else st_nxt = gfp_pkg::ST_E_DIVS;
      end
      gfp_pkg::ST_E_DIVS: st_nxt = gfp_pkg::ST_E_DIVW;
      gfp_pkg::ST_E_DIVW: if (stat.div_done) st_nxt = gfp_pkg::ST_E_RDP;
      gfp_pkg::ST_E_RDP:  st_nxt = cj_is_pc ? e_next : gfp_pkg::ST_E_MUL;
      gfp_pkg::ST_E_MUL:  st_nxt = gfp_pkg::ST_E_RND;
      gfp_pkg::ST_E_RND:  st_nxt = gfp_pkg::ST_E_WR;
      gfp_pkg::ST_E_WR:   st_nxt = e_next;
      gfp_pkg::ST_R_RD:   st_nxt = gfp_pkg::ST_R_WR;
      gfp_pkg::ST_R_WR:   st_nxt = gfp_pkg::ST_R_CLR;
      gfp_pkg::ST_R_CLR: begin
        if (col_end) st_nxt = (k_r == LAST_ROW) ? gfp_pkg::ST_B_RD : gfp_pkg::ST_S_RD;
        else st_nxt = gfp_pkg::ST_R_RD;
      end
      gfp_pkg::ST_B_RD:   st_nxt = gfp_pkg::ST_B_CHK;
      gfp_pkg::ST_B_CHK:  st_nxt = stat.rd_zero ? bj_next : gfp_pkg::ST_B_DIVS;
      gfp_pkg::ST_B_DIVS: st_nxt = gfp_pkg::ST_B_DIVW;
      gfp_pkg::ST_B_DIVW: if (stat.div_done) st_nxt = gfp_pkg::ST_B_RR;
      gfp_pkg::ST_B_RR: begin
        if (r_self) st_nxt = r_end ? bj_next : gfp_pkg::ST_B_RR;
        else st_nxt = gfp_pkg::ST_B_RM;
      end
      gfp_pkg::ST_B_RM:   st_nxt = gfp_pkg::ST_B_RND;
      gfp_pkg::ST_B_RND:  st_nxt = gfp_pkg::ST_B_RW;
      gfp_pkg::ST_B_RW:   st_nxt = gfp_pkg::ST_B_RZ;
      gfp_pkg::ST_B_RZ:   st_nxt = r_end ? bj_next : gfp_pkg::ST_B_RR;
      gfp_pkg::ST_OUT:    if (out_acc && oi_r == LAST_ROW) st_nxt = gfp_pkg::ST_IDLE;
      default:            st_nxt = gfp_pkg::ST_IDLE;
    endcase
  end

  // loop counters
  always_comb begin
    k_nxt     = k_r;
    ci_nxt    = ci_r;
    cj_nxt    = cj_r;
    cr_nxt    = cr_r;
    pr_nxt    = pr_r;
    pc_nxt    = pc_r;
    oi_nxt    = oi_r;
    act_nxt   = act_r;
    found_nxt = found_r;
    case (st_r)
      gfp_pkg::ST_INIT: begin
        k_nxt     = '0;
        ci_nxt    = '0;
        cj_nxt    = '0;
        oi_nxt    = '0;
        act_nxt   = '1;
        found_nxt = 1'b0;
      end
      gfp_pkg::ST_S_CMP: begin
        if (take) begin
          pr_nxt    = ci_r;
          pc_nxt    = cj_r[IW-1:0];
          found_nxt = 1'b1;
        end
        if (j_end) begin
          cj_nxt = '0;
          if (!row_end) ci_nxt = ci_r + 1'b1;
        end else begin
          cj_nxt = cj_r + 1'b1;
        end
      end
      gfp_pkg::ST_S_END: begin
        ci_nxt = '0;
        cj_nxt = '0;
      end
      gfp_pkg::ST_E_RDF: begin
        if (row_skip) begin
          if (row_end) cj_nxt = '0;
          else ci_nxt = ci_r + 1'b1;
        end
      end
      gfp_pkg::ST_E_DIVW: if (stat.div_done) cj_nxt = '0;
      gfp_pkg::ST_E_RDP, gfp_pkg::ST_E_WR: begin
        if (st_r == gfp_pkg::ST_E_WR || cj_is_pc) begin
          if (col_end) begin
            cj_nxt = '0;
            if (!row_end) ci_nxt = ci_r + 1'b1;
          end else begin
            cj_nxt = cj_r + 1'b1;
          end
        end
      end
      gfp_pkg::ST_R_CLR: begin
        if (col_end) begin
          act_nxt[pr_r] = 1'b0;
          cj_nxt        = '0;
          if (k_r == LAST_ROW) begin
            ci_nxt = LAST_ROW;
          end else begin
            k_nxt     = k_r + 1'b1;
            ci_nxt    = '0;
            found_nxt = 1'b0;
          end
        end else begin
          cj_nxt = cj_r + 1'b1;
        end
      end
      gfp_pkg::ST_B_CHK, gfp_pkg::ST_B_RR, gfp_pkg::ST_B_RZ: begin
        if ((st_r == gfp_pkg::ST_B_CHK && stat.rd_zero) ||
            (st_r != gfp_pkg::ST_B_CHK && r_end && (r_self || st_r == gfp_pkg::ST_B_RZ))) begin
          if (j_end) begin
            cj_nxt = '0;
            if (!i_end) ci_nxt = ci_r - 1'b1;
          end else begin
            cj_nxt = cj_r + 1'b1;
          end
        end else if (st_r == gfp_pkg::ST_B_RZ || (st_r == gfp_pkg::ST_B_RR && r_self)) begin
          cr_nxt = cr_r + 1'b1;
        end
      end
      gfp_pkg::ST_B_DIVW: if (stat.div_done) cr_nxt = '0;
      gfp_pkg::ST_OUT:    if (out_acc) oi_nxt = oi_r + 1'b1;
      default: ;
    endcase
  end

  always_comb begin
    cmd           = '0;
    cmd.wsel      = gfp_pkg::WS_ZERO;
    cmd.mem_addr  = gfp_pkg::mk_addr(gfp_pkg::BANK_MAT, ci_r, cj_r);
    cmd.sol_idx   = cj_r[IW-1:0];
    cmd.out_idx   = oi_r;
    in_ready      = 1'b0;
    out_valid     = 1'b0;
    out_last      = 1'b0;
    case (st_r)
      gfp_pkg::ST_IDLE: begin
        in_ready     = 1'b1;
        cmd.mem_addr = gfp_pkg::mk_addr(gfp_pkg::BANK_MAT, in_row, in_col);
        cmd.wsel     = gfp_pkg::WS_IN;
        cmd.mem_we   = in_acc && (int'(in_row) < N) && (in_col <= RHS_COL);
      end
      gfp_pkg::ST_INIT: begin
        cmd.sol_clr  = 1'b1;
        cmd.sing_clr = 1'b1;
      end
      gfp_pkg::ST_S_CMP:  cmd.piv_ld = take;
      gfp_pkg::ST_S_END:  cmd.sing_set = stat.best_zero;
      gfp_pkg::ST_E_RDF:  cmd.mem_addr = gfp_pkg::mk_addr(gfp_pkg::BANK_MAT, ci_r, CW'(pc_r));
      gfp_pkg::ST_E_DIVS: cmd.div_start = 1'b1;
      gfp_pkg::ST_E_DIVW: cmd.f_ld = stat.div_done;
      gfp_pkg::ST_E_RDP: begin
        if (cj_is_pc) cmd.mem_we = 1'b1;
        else cmd.mem_addr = gfp_pkg::mk_addr(gfp_pkg::BANK_MAT, pr_r, cj_r);
      end
      gfp_pkg::ST_E_WR: begin
        cmd.mem_we = 1'b1;
        cmd.wsel   = gfp_pkg::WS_SUB;
      end
      gfp_pkg::ST_R_RD:   cmd.mem_addr = gfp_pkg::mk_addr(gfp_pkg::BANK_MAT, pr_r, cj_r);
      gfp_pkg::ST_R_WR: begin
        cmd.mem_we   = 1'b1;
        cmd.wsel     = gfp_pkg::WS_RD;
        cmd.mem_addr = gfp_pkg::mk_addr(gfp_pkg::BANK_RET, k_r, cj_r);
      end
      gfp_pkg::ST_R_CLR: begin
        cmd.mem_we   = 1'b1;
        cmd.mem_addr = gfp_pkg::mk_addr(gfp_pkg::BANK_MAT, pr_r, cj_r);
      end
      gfp_pkg::ST_B_RD:   cmd.mem_addr = gfp_pkg::mk_addr(gfp_pkg::BANK_RET, ci_r, cj_r);
      gfp_pkg::ST_B_CHK: begin
        cmd.piv_ld   = !stat.rd_zero;
        cmd.mem_addr = gfp_pkg::mk_addr(gfp_pkg::BANK_RET, ci_r, RHS_COL);
      end
      gfp_pkg::ST_B_DIVS: cmd.div_start = 1'b1;
      gfp_pkg::ST_B_DIVW: begin
        cmd.f_ld   = stat.div_done;
        cmd.sol_ld = stat.div_done;
      end
      gfp_pkg::ST_B_RR:   cmd.mem_addr = gfp_pkg::mk_addr(gfp_pkg::BANK_RET, cr_r, cj_r);
      gfp_pkg::ST_B_RM:   cmd.mem_addr = gfp_pkg::mk_addr(gfp_pkg::BANK_RET, cr_r, RHS_COL);
      gfp_pkg::ST_B_RW: begin
        cmd.mem_we   = 1'b1;
        cmd.wsel     = gfp_pkg::WS_SUB;
        cmd.mem_addr = gfp_pkg::mk_addr(gfp_pkg::BANK_RET, cr_r, RHS_COL);
      end
      gfp_pkg::ST_B_RZ: begin
        cmd.mem_we   = 1'b1;
        cmd.mem_addr = gfp_pkg::mk_addr(gfp_pkg::BANK_RET, cr_r, cj_r);
      end
      gfp_pkg::ST_OUT: begin
        out_valid = 1'b1;
        out_last  = (oi_r == LAST_ROW);
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/gfp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module gfp_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [1:0] out_index,
  input wire logic       out_singular,
  input wire logic       out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  a_index_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_index == $past(out_index) + 2'd1))
    else $error("result index did not advance");

  a_sing_steady: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=> out_singular == $past(out_singular))
    else $error("singular flag changed within a run");

  a_run_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && out_last |=> !out_valid && in_ready)
    else $error("block not idle after last result");

endmodule

bind gauss_full_pivot_solver gfp_checker u_gfp_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_ch.valid),
  .in_ready     (in_ch.ready),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .out_index    (out_ch.unknown_index),
  .out_singular (out_ch.singular),
  .out_last     (out_ch.last_result)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
  import gfp_pkg::*;

  typedef struct packed {
    logic [1:0]         row;
    logic [2:0]         col;
    logic signed [31:0] val;
    logic               last;
  } elem_t;

  typedef struct packed {
    logic [1:0]         idx;
    logic signed [31:0] val;
    logic               sing;
    logic               last;
  } sol_t;

  localparam int NC = SIZE + 1;
  localparam longint CYCLE_LIMIT = 3000000;

  logic clk;
  logic rst_n;
  gfp_in_if  in_ch ();
  gfp_out_if out_ch ();

  gauss_full_pivot_solver u_dut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch));

  logic signed [31:0] mat [SIZE][NC];
  logic signed [31:0] ret [SIZE][NC];
  elem_t pending_words[$];
  sol_t  expected_solutions[$];
  int    errors;
  int    results_seen;
  int    hold_off;
  int    pause_len;
  bit    stim_done;
  bit    long_hold_req;
  longint cycles;

  function automatic logic [63:0] magn(input logic signed [31:0] v);
    return v < 0 ? 64'(-64'(v)) : 64'(v);
  endfunction

  function automatic logic signed [31:0] sat(input longint v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] fx_mul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic [63:0] m;
    m = magn(a) * magn(b);
    m = (m + (64'd1 << (FRAC - 1))) >> FRAC;
    return sat(((a < 0) != (b < 0)) ? -longint'(m) : longint'(m));
  endfunction

  function automatic logic signed [31:0] fx_div(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    logic [63:0] n, d, q;
    if (b == 0) return 0;
    n = magn(a) << FRAC;
    d = magn(b);
    q = (n + d / 2) / d;
    return sat(((a < 0) != (b < 0)) ? -longint'(q) : longint'(q));
  endfunction

  function automatic logic signed [31:0] fx_sub(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
    return sat(longint'(a) - longint'(b));
  endfunction

  task automatic solve_system();
    logic [SIZE-1:0] act;
    logic signed [31:0] sol [SIZE];
    logic signed [31:0] piv, f;
    logic [63:0] best;
    logic sing;
    int pr, pc;
    sol_t s;
    act = '1;
    sing = 0;
    for (int j = 0; j < SIZE; j++) sol[j] = 0;
    for (int k = 0; k < SIZE; k++) begin
      pr = -1; pc = 0; best = 0;
      for (int i = 0; i < SIZE; i++) begin
        if (!act[i]) continue;
        for (int j = 0; j < SIZE; j++)
          if (pr < 0 || magn(mat[i][j]) > best) begin
            pr = i; pc = j; best = magn(mat[i][j]);
          end
      end
      if (pr < 0) pr = 0;
      if (best == 0) begin
        sing = 1;
      end else begin
        piv = mat[pr][pc];
        for (int i = 0; i < SIZE; i++) begin
          if (i == pr || !act[i]) continue;
          f = fx_div(mat[i][pc], piv);
          for (int j = 0; j < NC; j++)
            mat[i][j] = (j == pc) ? 32'sd0 : fx_sub(mat[i][j], fx_mul(mat[pr][j], f));
        end
      end
      for (int j = 0; j < NC; j++) begin
        ret[k][j] = mat[pr][j];
        mat[pr][j] = 0;
      end
      act[pr] = 0;
    end
    for (int i = SIZE - 1; i >= 0; i--)
      for (int j = 0; j < SIZE; j++) begin
        if (ret[i][j] == 0) continue;
        sol[j] = fx_div(ret[i][SIZE], ret[i][j]);
        for (int r = 0; r < SIZE; r++) begin
          if (r == i) continue;
          ret[r][SIZE] = fx_sub(ret[r][SIZE], fx_mul(ret[r][j], sol[j]));
          ret[r][j] = 0;
        end
      end
    for (int j = 0; j < SIZE; j++) begin
      s.idx = j; s.val = sol[j]; s.sing = sing; s.last = (j == SIZE - 1);
      expected_solutions.push_back(s);
    end
  endtask

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0h want %0h", what, got, want);
    errors++;
  endtask

  function automatic logic signed [31:0] rand_val(input int style);
    case (style)
      0: return $urandom;
      1: return $signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000;
      2: return ($urandom_range(0, 1)) ? 32'sh7fffffff : 32'sh80000000;
      3: return 0;
      default: return $signed($urandom_range(0, 20) - 10) <<< FRAC;
    endcase
  endfunction

  task automatic push_word(input int r, input int c, input logic signed [31:0] v, input bit l);
    elem_t e;
    e.row = r; e.col = c; e.val = v; e.last = l;
    pending_words.push_back(e);
  endtask

  // full matrix load; the final element carries last
  task automatic push_matrix(input int style, input bit zero_col);
    int lr, lc;
    lr = $urandom_range(0, SIZE - 1);
    lc = $urandom_range(0, SIZE);
    for (int r = 0; r < SIZE; r++)
      for (int c = 0; c < NC; c++)
        if (!(r == lr && c == lc))
          push_word(r, c, (zero_col && c == 1) ? 32'sd0 : rand_val(style), 0);
    push_word(lr, lc, (zero_col && lc == 1) ? 32'sd0 : rand_val(style), 1);
  endtask

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  // driver
  int gap;
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 0;
      gap <= 0;
    end else if (in_ch.valid && !in_ch.ready) begin
    end else if (pause_len > 0 && (expected_solutions.size() != 0 || pause_len > 1)) begin
      in_ch.valid <= 0;
      if (expected_solutions.size() == 0) pause_len <= pause_len - 1;
    end else if (gap > 0) begin
      in_ch.valid <= 0;
      gap <= gap - 1;
    end else if (pending_words.size() != 0) begin
      elem_t e;
      e = pending_words.pop_front();
      if (e.row < SIZE && e.col <= SIZE) mat[e.row][e.col] = e.val;
      if (e.last) solve_system();
      in_ch.valid         <= 1;
      in_ch.row_index     <= e.row;
      in_ch.column_index  <= e.col;
      in_ch.element_value <= e.val;
      in_ch.last_element  <= e.last;
      gap <= ($urandom_range(0, 3) == 0) ? $urandom_range(0, 13) : 0;
      if (e.last && $urandom_range(0, 15) == 0) pause_len <= 2;
    end else begin
      in_ch.valid <= 0;
    end
  end

  // monitor and receiver
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (!rst_n) begin
      out_ch.ready <= 0;
      hold_off <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        sol_t w;
        results_seen++;
        if (expected_solutions.size() == 0) begin
          report("unexpected word", out_ch.unknown_index, 0);
        end else begin
          w = expected_solutions.pop_front();
          if (out_ch.unknown_index !== w.idx) report("index", out_ch.unknown_index, w.idx);
          if (out_ch.unknown_value !== w.val)
            report("value", 32'(out_ch.unknown_value), 32'(w.val));
          if (out_ch.singular !== w.sing) report("singular", out_ch.singular, w.sing);
          if (out_ch.last_result !== w.last) report("last", out_ch.last_result, w.last);
        end
      end
      if (long_hold_req && hold_off == 0) begin
        hold_off <= 3000;
        long_hold_req <= 0;
        out_ch.ready <= 0;
      end else if (hold_off > 0) begin
        hold_off <= hold_off - 1;
        out_ch.ready <= 0;
      end else if (out_ch.valid && out_ch.ready || !out_ch.ready) begin
        int d;
        d = ($urandom_range(0, 2) == 0) ? $urandom_range(0, 13) : 0;
        hold_off <= d;
        out_ch.ready <= (d == 0);
      end
    end
    if (cycles > CYCLE_LIMIT) begin
      $display("testbench: errors");
      $finish;
    end
  end

  initial begin
    int style;
    errors = 0; results_seen = 0; cycles = 0; pause_len = 0;
    stim_done = 0; long_hold_req = 0;
    for (int r = 0; r < SIZE; r++)
      for (int c = 0; c < NC; c++) begin
        mat[r][c] = 0; ret[r][c] = 0;
      end
    in_ch.valid = 0; in_ch.row_index = 0; in_ch.column_index = 0;
    in_ch.element_value = 0; in_ch.last_element = 0;
    out_ch.ready = 0;
    rst_n = 0;
    repeat (6) @(posedge clk);
    rst_n <= 1;
    // directed: extremes, out-of-range indexes, a diagonal system, singular system
    for (int r = 0; r < SIZE; r++)
      for (int c = 0; c < NC; c++)
        push_word(r, c, (c == SIZE) ? 32'sh7fffffff : ((r == c) ? 32'sh0000_0001 : 32'sd0), 0);
    push_word(3, 7, 32'sh80000000, 0);
    push_word(3, 5, 32'sh12345678, 0);
    push_word(0, 0, 32'sh80000000, 1);
    long_hold_req = 1;
    push_matrix(2, 0);
    push_matrix(3, 0);
    push_matrix(4, 1);
    push_word(2, 6, 32'sh7fffffff, 1);
    while (pending_words.size() != 0) @(posedge clk);
    pause_len = 2;
    while (pending_words.size() + expected_solutions.size() != 0) @(posedge clk);
    for (int n = 0; n < 22; n++) begin
      style = $urandom_range(0, 4);
      if ($urandom_range(0, 9) == 0) push_word($urandom_range(0, 3), $urandom_range(0, 7),
                                               rand_val(0), $urandom_range(0, 1));
      push_matrix(style, $urandom_range(0, 5) == 0);
      if (n == 10) long_hold_req = 1;
      while (pending_words.size() > 30) @(posedge clk);
    end
    while (pending_words.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_solutions.size() != 0) @(posedge clk);
    repeat (1200) @(posedge clk);
    if (errors == 0 && expected_solutions.size() == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end
endmodule
